// File: rtl/tmef_pkg.sv
package tmef_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;  // stored sample, median and average width
    localparam int IN_W      = 17;  // raw signed sample width
    localparam int ALPHA_W   = 3;
    localparam int FENCE_W   = 4;
    localparam int MINC_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int MAX_CH    = 4;

    // Fence arithmetic: fence_halves * iqr, and doubled-scale compare operands
    localparam int PROD_W = FENCE_W + SAMPLE_W;
    localparam int CMP_W  = PROD_W + 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FENCE_HALVES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLEAN    = 2'd2;

    // Configuration reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 3'd2;
    localparam logic [FENCE_W-1:0] FENCE_RST = 4'd3;
    localparam logic [MINC_W-1:0]  MINC_RST  = 5'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_KEY_RD,
        ST_KEY_LD,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_RANK_WR,
        ST_Q1_RD,
        ST_Q1_LD,
        ST_Q3_RD,
        ST_Q3_LD,
        ST_MED_RD,
        ST_MED_LD,
        ST_FENCE_MUL,
        ST_FENCE_SET,
        ST_SCAN_RD,
        ST_SCAN_LO,
        ST_SCAN_HI,
        ST_PICK_RD,
        ST_PICK_LD,
        ST_AVG,
        ST_DONE
    } state_t;

endpackage

// File: rtl/tukey_median_ema_filter.sv
// A beat that does not finish a batch is written to the sample memory channel by channel;
// a failed read gives its result beat in the cycle after acceptance. A finishing beat
// also runs the rank sort, fences and averages of every channel, its time set by the
// single-port rank sort on one shared comparator. One beat in flight.
// Reset (aresetn, synchronous, active low): sample count, averages, primed flag and
// output valid clear; registers return to alpha_shift=2, fence_halves=3, min_clean=3.
module tukey_median_ema_filter #(
    parameter int SAMPLES  = 5,
    parameter int CHANNELS = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration write port
    input  logic                                  cfg_we,
    input  logic [tmef_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tmef_pkg::CFG_DAT_W-1:0]        cfg_wdata,

    // sample channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tmef_pkg::IN_W-1:0]      s_pm1_sample,
    input  logic signed [tmef_pkg::IN_W-1:0]      s_pm25_sample,
    input  logic signed [tmef_pkg::IN_W-1:0]      s_pm4_sample,
    input  logic signed [tmef_pkg::IN_W-1:0]      s_pm10_sample,
    input  logic                                  s_read_ok,

    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm1_median,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm25_median,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm4_median,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm10_median,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm1_average,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm25_average,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm4_average,
    output logic [tmef_pkg::SAMPLE_W-1:0]         m_pm10_average,
    output logic                                  m_batch_ok
);

    localparam int SW     = tmef_pkg::SAMPLE_W;
    localparam int CMPW   = tmef_pkg::CMP_W;
    localparam int PRODW  = tmef_pkg::PROD_W;
    localparam int MCW    = tmef_pkg::MINC_W;
    localparam int NCH    = tmef_pkg::MAX_CH;
    localparam int IW     = $clog2(SAMPLES);                      // sample index
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1; // channel index
    localparam int CNTW   = $clog2(SAMPLES + 1);                  // counts 0..SAMPLES
    localparam int DEPTH  = 1 << (CW + IW);

    // sorted positions of the quartiles and the plain median
    localparam logic [IW-1:0] Q1_POS   = IW'(SAMPLES / 4);
    localparam logic [IW-1:0] Q3_POS   = IW'((3 * SAMPLES) / 4);
    localparam logic [IW-1:0] MED_POS  = IW'(SAMPLES / 2);
    localparam logic [IW-1:0] LAST_POS = IW'(SAMPLES - 1);
    localparam logic [CW-1:0] LAST_CH  = CW'(CHANNELS - 1);

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    tmef_pkg::state_t state_reg, state_next;

    logic [tmef_pkg::ALPHA_W-1:0] alpha_reg;
    logic [tmef_pkg::FENCE_W-1:0] fence_reg;
    logic [MCW-1:0]               minc_reg;

    logic [IW-1:0]   count_reg, count_next;   // samples held in the open batch
    logic [CW-1:0]   ch_reg, ch_next;
    logic [IW-1:0]   i_reg, i_next;           // outer index (sort, scan)
    logic [IW-1:0]   j_reg, j_next;           // inner index (rank compare)
    logic [IW-1:0]   rank_reg, rank_next;
    logic [SW-1:0]   key_reg, key_next;
    logic [SW-1:0]   q1_reg, q1_next;
    logic [SW-1:0]   q3_reg, q3_next;
    logic [SW-1:0]   plain_reg, plain_next;
    logic [PRODW-1:0] prod_reg, prod_next;
    logic signed [CMPW-1:0] lo2_reg, lo2_next;
    logic signed [CMPW-1:0] hi2_reg, hi2_next;
    logic signed [CMPW-1:0] x2_reg, x2_next;
    logic [CNTW-1:0] nlo_reg, nlo_next;       // sorted samples below the low fence
    logic [CNTW-1:0] nk_reg, nk_next;         // samples inside the fences
    logic [SW-1:0]   samp_reg [CHANNELS];
    logic [SW-1:0]   samp_next [CHANNELS];
    logic [SW-1:0]   med_reg [NCH];
    logic [SW-1:0]   med_next [NCH];
    logic [SW-1:0]   avg_reg [NCH];
    logic [SW-1:0]   avg_next [NCH];
    logic            primed_reg, primed_next;
    logic            m_valid_reg, m_valid_next;
    logic            batch_ok_reg, batch_ok_next;

    // memories: raw samples per channel, and the sorted copy of one channel
    logic [SW-1:0]   smp_mem [DEPTH];
    logic [SW-1:0]   srt_mem [SAMPLES];
    logic [SW-1:0]   mem_rd_reg;
    logic [SW-1:0]   srt_rd_reg;

    //------------------------------------------------------------------
    // Control decode
    //------------------------------------------------------------------
    logic                   accept;
    logic                   mem_we;
    logic [CW+IW-1:0]       mem_waddr;
    logic [CW+IW-1:0]       mem_raddr;
    logic                   srt_we;
    logic [IW-1:0]          srt_raddr;
    logic signed [CMPW-1:0] cmp_a, cmp_b;
    logic                   cmp_lt;           // shared comparator: cmp_a < cmp_b
    logic                   use_clean;
    logic [CNTW-1:0]        pick_sum;

    logic signed [tmef_pkg::IN_W-1:0] in_raw [NCH];

    // EMA step
    logic [SW:0]   ema_d;
    logic [SW:0]   ema_neg;
    logic [SW-1:0] ema_mag;
    logic [SW-1:0] ema_sh;
    logic [SW-1:0] ema_new;

    assign in_raw[0] = s_pm1_sample;
    assign in_raw[1] = s_pm25_sample;
    assign in_raw[2] = s_pm4_sample;
    assign in_raw[3] = s_pm10_sample;

    // The result register parts the two sides: a new beat is taken when the
    // result slot is empty or is being emptied this cycle.
    assign s_ready = (state_reg == tmef_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign cmp_lt    = cmp_a < cmp_b;
    assign use_clean = (nk_reg != '0) && (MCW'(nk_reg) >= minc_reg);
    assign pick_sum  = nlo_reg + (nk_reg >> 1);

    // Kept samples are a contiguous run of the sorted list (the fences bound an
    // interval), so the cleaned median sits at nlo + nk/2.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {ch_reg, count_reg};
        mem_raddr = {ch_reg, i_reg};
        srt_we    = 1'b0;
        srt_raddr = i_reg;
        cmp_a     = '0;
        cmp_b     = '0;
        unique case (state_reg)
            tmef_pkg::ST_WRITE: begin
                mem_we = 1'b1;
            end
            tmef_pkg::ST_CMP_RD: begin
                mem_raddr = {ch_reg, j_reg};
            end
            tmef_pkg::ST_CMP_CHK: begin
                // rank with ties broken by index: earlier equal samples rank lower
                if (j_reg < i_reg) begin
                    cmp_a = $signed(CMPW'(key_reg));
                    cmp_b = $signed(CMPW'(mem_rd_reg));
                end else begin
                    cmp_a = $signed(CMPW'(mem_rd_reg));
                    cmp_b = $signed(CMPW'(key_reg));
                end
            end
            tmef_pkg::ST_RANK_WR: begin
                srt_we = 1'b1;
            end
            tmef_pkg::ST_Q1_RD:  srt_raddr = Q1_POS;
            tmef_pkg::ST_Q3_RD:  srt_raddr = Q3_POS;
            tmef_pkg::ST_MED_RD: srt_raddr = MED_POS;
            tmef_pkg::ST_SCAN_LO: begin
                cmp_a = $signed(CMPW'({srt_rd_reg, 1'b0}));
                cmp_b = lo2_reg;
            end
            tmef_pkg::ST_SCAN_HI: begin
                cmp_a = hi2_reg;
                cmp_b = x2_reg;
            end
            tmef_pkg::ST_PICK_RD: srt_raddr = pick_sum[IW-1:0];
            default: begin
            end
        endcase
    end

    // average += (median - average) / 2^alpha_shift, quotient truncated toward zero
    always_comb begin
        ema_d   = {1'b0, med_reg[ch_reg]} - {1'b0, avg_reg[ch_reg]};
        ema_neg = -ema_d;
        ema_mag = ema_d[SW] ? ema_neg[SW-1:0] : ema_d[SW-1:0];
        ema_sh  = ema_mag >> alpha_reg;
        ema_new = ema_d[SW] ? (avg_reg[ch_reg] - ema_sh) : (avg_reg[ch_reg] + ema_sh);
    end

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmef_pkg::ST_IDLE: begin
                if (accept && s_read_ok) state_next = tmef_pkg::ST_WRITE;
            end
            tmef_pkg::ST_WRITE: begin
                if (ch_reg == LAST_CH) begin
                    state_next = (count_reg == LAST_POS) ? tmef_pkg::ST_KEY_RD
                                                         : tmef_pkg::ST_IDLE;
                end
            end
            tmef_pkg::ST_KEY_RD:  state_next = tmef_pkg::ST_KEY_LD;
            tmef_pkg::ST_KEY_LD:  state_next = tmef_pkg::ST_CMP_RD;
            tmef_pkg::ST_CMP_RD:  state_next = tmef_pkg::ST_CMP_CHK;
            tmef_pkg::ST_CMP_CHK: begin
                state_next = (j_reg == LAST_POS) ? tmef_pkg::ST_RANK_WR
                                                 : tmef_pkg::ST_CMP_RD;
            end
            tmef_pkg::ST_RANK_WR: begin
                state_next = (i_reg == LAST_POS) ? tmef_pkg::ST_Q1_RD
                                                 : tmef_pkg::ST_KEY_RD;
            end
            tmef_pkg::ST_Q1_RD:     state_next = tmef_pkg::ST_Q1_LD;
            tmef_pkg::ST_Q1_LD:     state_next = tmef_pkg::ST_Q3_RD;
            tmef_pkg::ST_Q3_RD:     state_next = tmef_pkg::ST_Q3_LD;
            tmef_pkg::ST_Q3_LD:     state_next = tmef_pkg::ST_MED_RD;
            tmef_pkg::ST_MED_RD:    state_next = tmef_pkg::ST_MED_LD;
            tmef_pkg::ST_MED_LD:    state_next = tmef_pkg::ST_FENCE_MUL;
            tmef_pkg::ST_FENCE_MUL: state_next = tmef_pkg::ST_FENCE_SET;
            tmef_pkg::ST_FENCE_SET: state_next = tmef_pkg::ST_SCAN_RD;
            tmef_pkg::ST_SCAN_RD:   state_next = tmef_pkg::ST_SCAN_LO;
            tmef_pkg::ST_SCAN_LO: begin
                if (!cmp_lt) begin
                    state_next = tmef_pkg::ST_SCAN_HI;
                end else begin
                    state_next = (i_reg == LAST_POS) ? tmef_pkg::ST_PICK_RD
                                                     : tmef_pkg::ST_SCAN_RD;
                end
            end
            tmef_pkg::ST_SCAN_HI: begin
                state_next = (i_reg == LAST_POS) ? tmef_pkg::ST_PICK_RD
                                                 : tmef_pkg::ST_SCAN_RD;
            end
            tmef_pkg::ST_PICK_RD: state_next = tmef_pkg::ST_PICK_LD;
            tmef_pkg::ST_PICK_LD: state_next = tmef_pkg::ST_AVG;
            tmef_pkg::ST_AVG: begin
                state_next = (ch_reg == LAST_CH) ? tmef_pkg::ST_DONE
                                                 : tmef_pkg::ST_KEY_RD;
            end
            tmef_pkg::ST_DONE: state_next = tmef_pkg::ST_IDLE;
            default:           state_next = tmef_pkg::ST_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // Datapath next values
    //------------------------------------------------------------------
    always_comb begin
        count_next    = count_reg;
        ch_next       = ch_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rank_next     = rank_reg;
        key_next      = key_reg;
        q1_next       = q1_reg;
        q3_next       = q3_reg;
        plain_next    = plain_reg;
        prod_next     = prod_reg;
        lo2_next      = lo2_reg;
        hi2_next      = hi2_reg;
        x2_next       = x2_reg;
        nlo_next      = nlo_reg;
        nk_next       = nk_reg;
        samp_next     = samp_reg;
        med_next      = med_reg;
        avg_next      = avg_reg;
        primed_next   = primed_reg;
        batch_ok_next = batch_ok_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            tmef_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_read_ok) begin
                        // negative samples clamp to zero
                        for (int c = 0; c < CHANNELS; c++) begin
                            samp_next[c] = in_raw[c][SW] ? '0 : in_raw[c][SW-1:0];
                        end
                        ch_next = '0;
                    end else begin
                        // failed read: drop the batch, report stored averages
                        count_next    = '0;
                        for (int c = 0; c < NCH; c++) med_next[c] = '0;
                        batch_ok_next = 1'b0;
                        m_valid_next  = 1'b1;
                    end
                end
            end
            tmef_pkg::ST_WRITE: begin
                if (ch_reg == LAST_CH) begin
                    ch_next = '0;
                    i_next  = '0;
                    count_next = (count_reg == LAST_POS) ? '0 : count_reg + 1'b1;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            tmef_pkg::ST_KEY_LD: begin
                key_next  = mem_rd_reg;
                j_next    = '0;
                rank_next = '0;
            end
            tmef_pkg::ST_CMP_CHK: begin
                if ((j_reg < i_reg) ? !cmp_lt : cmp_lt) rank_next = rank_reg + 1'b1;
                if (j_reg != LAST_POS) j_next = j_reg + 1'b1;
            end
            tmef_pkg::ST_RANK_WR: begin
                i_next = (i_reg == LAST_POS) ? '0 : i_reg + 1'b1;
            end
            tmef_pkg::ST_Q1_LD:  q1_next    = srt_rd_reg;
            tmef_pkg::ST_Q3_LD:  q3_next    = srt_rd_reg;
            tmef_pkg::ST_MED_LD: plain_next = srt_rd_reg;
            tmef_pkg::ST_FENCE_MUL: begin
                prod_next = PRODW'(fence_reg) * PRODW'(q3_reg - q1_reg);
            end
            tmef_pkg::ST_FENCE_SET: begin
                // closed fences at doubled scale
                lo2_next = $signed(CMPW'({q1_reg, 1'b0})) - $signed(CMPW'(prod_reg));
                hi2_next = $signed(CMPW'({q3_reg, 1'b0})) + $signed(CMPW'(prod_reg));
                i_next   = '0;
                nlo_next = '0;
                nk_next  = '0;
            end
            tmef_pkg::ST_SCAN_LO: begin
                if (cmp_lt) begin
                    nlo_next = nlo_reg + 1'b1;
                    i_next   = (i_reg == LAST_POS) ? '0 : i_reg + 1'b1;
                end else begin
                    x2_next = $signed(CMPW'({srt_rd_reg, 1'b0}));
                end
            end
            tmef_pkg::ST_SCAN_HI: begin
                if (!cmp_lt) nk_next = nk_reg + 1'b1;
                i_next = (i_reg == LAST_POS) ? '0 : i_reg + 1'b1;
            end
            tmef_pkg::ST_PICK_LD: begin
                med_next[ch_reg] = use_clean ? srt_rd_reg : plain_reg;
            end
            tmef_pkg::ST_AVG: begin
                avg_next[ch_reg] = primed_reg ? ema_new : med_reg[ch_reg];
                ch_next = (ch_reg == LAST_CH) ? '0 : ch_reg + 1'b1;
            end
            tmef_pkg::ST_DONE: begin
                primed_next   = 1'b1;
                batch_ok_next = 1'b1;
                m_valid_next  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmef_pkg::ST_IDLE;
            count_reg   <= '0;
            ch_reg      <= '0;
            i_reg       <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                med_reg[c] <= '0;
                avg_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ch_reg      <= ch_next;
            i_reg       <= i_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
            med_reg     <= med_next;
            avg_reg     <= avg_next;
        end
    end

    // configuration registers; writes to an unknown index are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= tmef_pkg::ALPHA_RST;
            fence_reg <= tmef_pkg::FENCE_RST;
            minc_reg  <= tmef_pkg::MINC_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tmef_pkg::CFG_ALPHA_SHIFT:  alpha_reg <= cfg_wdata[tmef_pkg::ALPHA_W-1:0];
                tmef_pkg::CFG_FENCE_HALVES: fence_reg <= cfg_wdata[tmef_pkg::FENCE_W-1:0];
                tmef_pkg::CFG_MIN_CLEAN:    minc_reg  <= cfg_wdata[MCW-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        rank_reg     <= rank_next;
        key_reg      <= key_next;
        q1_reg       <= q1_next;
        q3_reg       <= q3_next;
        plain_reg    <= plain_next;
        prod_reg     <= prod_next;
        lo2_reg      <= lo2_next;
        hi2_reg      <= hi2_next;
        x2_reg       <= x2_next;
        nlo_reg      <= nlo_next;
        nk_reg       <= nk_next;
        samp_reg     <= samp_next;
        batch_ok_reg <= batch_ok_next;
    end

    //------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) smp_mem[mem_waddr] <= samp_reg[ch_reg];
        mem_rd_reg <= smp_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (srt_we) srt_mem[rank_reg] <= key_reg;
        srt_rd_reg <= srt_mem[srt_raddr];
    end

    //------------------------------------------------------------------
    // Result beat
    //------------------------------------------------------------------
    assign m_valid        = m_valid_reg;
    assign m_batch_ok     = batch_ok_reg;
    assign m_pm1_median   = med_reg[0];
    assign m_pm25_median  = med_reg[1];
    assign m_pm4_median   = med_reg[2];
    assign m_pm10_median  = med_reg[3];
    assign m_pm1_average  = avg_reg[0];
    assign m_pm25_average = avg_reg[1];
    assign m_pm4_average  = avg_reg[2];
    assign m_pm10_average = avg_reg[3];

endmodule

// File: dv/tukey_median_ema_filter_tb.sv
`timescale 1ns / 100ps

module tukey_median_ema_filter_tb;

    localparam int SAMPLES  = 5;
    localparam int CHANNELS = 4;

    localparam int MAX_CH    = tmef_pkg::MAX_CH;
    localparam int IN_W      = tmef_pkg::IN_W;
    localparam int SAMPLE_W  = tmef_pkg::SAMPLE_W;
    localparam int CFG_IDX_W = tmef_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = tmef_pkg::CFG_DAT_W;
    localparam int ALPHA_W   = tmef_pkg::ALPHA_W;
    localparam int FENCE_W   = tmef_pkg::FENCE_W;
    localparam int MINC_W    = tmef_pkg::MINC_W;

    // A beat that does not close a batch keeps the block busy while it writes its samples.
    // Wait a settle window after that before touching the registers or ending the run.
    localparam int SETTLE_CYCLES = 4 * (CHANNELS + 1);
    // Roughly 110 batches, each closing with a full sort of every channel, plus heavy
    // stalls on both sides, stay far below this limit.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BEATS   = 85;

    // One input beat: raw signed samples in channel order pm1, pm25, pm4, pm10.
    typedef struct packed {
        logic [MAX_CH-1:0][IN_W-1:0] smp;
        logic                        ok;
    } pm_beat_t;

    // One result beat, with channels in the same order.
    typedef struct packed {
        logic [MAX_CH-1:0][SAMPLE_W-1:0] med;
        logic [MAX_CH-1:0][SAMPLE_W-1:0] avg;
        logic                            ok;
    } pm_result_t;

    logic aclk;
    logic aresetn;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    logic                   s_valid;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_pm1_sample;
    logic signed [IN_W-1:0] s_pm25_sample;
    logic signed [IN_W-1:0] s_pm4_sample;
    logic signed [IN_W-1:0] s_pm10_sample;
    logic                   s_read_ok;

    logic                m_valid;
    logic                m_ready;
    logic [SAMPLE_W-1:0] m_pm1_median;
    logic [SAMPLE_W-1:0] m_pm25_median;
    logic [SAMPLE_W-1:0] m_pm4_median;
    logic [SAMPLE_W-1:0] m_pm10_median;
    logic [SAMPLE_W-1:0] m_pm1_average;
    logic [SAMPLE_W-1:0] m_pm25_average;
    logic [SAMPLE_W-1:0] m_pm4_average;
    logic [SAMPLE_W-1:0] m_pm10_average;
    logic                m_batch_ok;

    tukey_median_ema_filter #(
        .SAMPLES  (SAMPLES),
        .CHANNELS (CHANNELS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pm1_sample   (s_pm1_sample),
        .s_pm25_sample  (s_pm25_sample),
        .s_pm4_sample   (s_pm4_sample),
        .s_pm10_sample  (s_pm10_sample),
        .s_read_ok      (s_read_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pm1_median   (m_pm1_median),
        .m_pm25_median  (m_pm25_median),
        .m_pm4_median   (m_pm4_median),
        .m_pm10_median  (m_pm10_median),
        .m_pm1_average  (m_pm1_average),
        .m_pm25_average (m_pm25_average),
        .m_pm4_average  (m_pm4_average),
        .m_pm10_average (m_pm10_average),
        .m_batch_ok     (m_batch_ok)
    );

    // ------------------------------------------------------------------
    // Shadow of the filter: settings, held samples, running averages
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]  shift_cfg;
    logic [FENCE_W-1:0]  fence_cfg;
    logic [MINC_W-1:0]   minc_cfg;
    logic [SAMPLE_W-1:0] smp_hist [MAX_CH][SAMPLES];
    int                  fill_cnt;
    logic [SAMPLE_W-1:0] ema_val [MAX_CH];
    logic                ema_primed;

    pm_beat_t   sample_beats [$];   // beats not yet put on the wire
    pm_result_t due_results [$];    // results the block still owes
    int         queued_cnt;
    int         accepted_cnt;
    int         mismatches;

    int       sender_idle_pct;
    int       receiver_idle_pct;
    logic     in_taken;             // the beat on the wire went in at the last rising edge
    pm_beat_t on_wire;
    pm_beat_t next_beat;

    pm_result_t got;
    pm_result_t want;
    int         ch_i;

    // Sort one channel, set the doubled-scale fences on the IQR and take the
    // median of the kept samples, or the plain median when too few survive.
    function automatic logic [SAMPLE_W-1:0] tukey_median(input int ch);
        logic [SAMPLE_W-1:0] srt  [SAMPLES];
        logic [SAMPLE_W-1:0] kept [SAMPLES];
        logic [SAMPLE_W-1:0] t;
        longint              q1, q3, iqr, lo2, hi2, x2, fk;
        int                  i, j, nk, mc;
        for (i = 0; i < SAMPLES; i++)
            srt[i] = smp_hist[ch][i];
        for (i = 1; i < SAMPLES; i++) begin
            for (j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
                t         = srt[j];
                srt[j]    = srt[j-1];
                srt[j-1]  = t;
            end
        end
        q1  = srt[SAMPLES/4];
        q3  = srt[(3*SAMPLES)/4];
        fk  = fence_cfg;
        iqr = q3 - q1;
        lo2 = 2*q1 - fk*iqr;
        hi2 = 2*q3 + fk*iqr;
        nk  = 0;
        for (i = 0; i < SAMPLES; i++) begin
            x2 = srt[i];
            x2 = 2*x2;
            if (x2 >= lo2 && x2 <= hi2) begin
                kept[nk] = srt[i];
                nk++;
            end
        end
        mc = minc_cfg;
        if (nk >= mc && nk > 0)
            return kept[nk/2];
        return srt[SAMPLES/2];
    endfunction

    // avg + (med - avg) / 2^shift, quotient truncated toward zero
    function automatic logic [SAMPLE_W-1:0] ema_step(input logic [SAMPLE_W-1:0] avg,
                                                     input logic [SAMPLE_W-1:0] med);
        int a, m, d, s;
        a = avg;
        m = med;
        d = m - a;
        if (d >= 0)
            d = d >> shift_cfg;
        else
            d = -((-d) >> shift_cfg);
        s = a + d;
        return s[SAMPLE_W-1:0];
    endfunction

    // Fold one accepted beat into the shadow state; queue the result it owes.
    task automatic absorb_sample(input pm_beat_t b);
        pm_result_t          r;
        logic [SAMPLE_W-1:0] med;
        int                  c;
        r = '0;
        if (!b.ok) begin
            // failed read: batch dropped, averages reported as they stand
            fill_cnt = 0;
            for (c = 0; c < CHANNELS; c++)
                r.avg[c] = ema_val[c];
            due_results.push_back(r);
        end else begin
            if (fill_cnt >= SAMPLES)
                fill_cnt = 0;
            for (c = 0; c < CHANNELS; c++)
                smp_hist[c][fill_cnt] = b.smp[c][IN_W-1] ? '0 : b.smp[c][SAMPLE_W-1:0];
            fill_cnt++;
            if (fill_cnt == SAMPLES) begin
                fill_cnt = 0;
                for (c = 0; c < CHANNELS; c++) begin
                    med        = tukey_median(c);
                    ema_val[c] = ema_primed ? ema_step(ema_val[c], med) : med;
                    r.med[c]   = med;
                    r.avg[c]   = ema_val[c];
                end
                ema_primed = 1'b1;
                r.ok       = 1'b1;
                due_results.push_back(r);
            end
        end
    endtask

    function automatic string chan_name(input int c);
        case (c)
            0:       return "pm1";
            1:       return "pm25";
            2:       return "pm4";
            default: return "pm10";
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                             input logic [IN_W-1:0] c, input logic [IN_W-1:0] d,
                             input logic ok);
        pm_beat_t bt;
        bt.smp[0] = a;
        bt.smp[1] = b;
        bt.smp[2] = c;
        bt.smp[3] = d;
        bt.ok     = ok;
        sample_beats.push_back(bt);
        queued_cnt++;
    endtask

    // Mostly values clustered around a center, with outliers, negatives,
    // full-scale and fully random raw words mixed in.
    function automatic logic [IN_W-1:0] draw_sample(input int unsigned center,
                                                    input int unsigned spread);
        int unsigned v;
        v = center + $urandom_range(0, spread);
        if (v > 65535)
            v = 65535;
        case ($urandom_range(0, 11))
            0:       return IN_W'($urandom);
            1:       return {1'b1, 16'($urandom)};
            2:       return {1'b0, 16'($urandom_range(0, 65535))};
            3:       return 17'h0FFFF;
            default: return {1'b0, v[15:0]};
        endcase
    endfunction

    // Whole batches with random content; now and then a failed read breaks one.
    task automatic queue_random_batches(input int n_beats);
        pm_beat_t    bt;
        int unsigned center [MAX_CH];
        int unsigned spread [MAX_CH];
        int          k, c, made;
        made = 0;
        while (made < n_beats) begin
            for (c = 0; c < MAX_CH; c++) begin
                center[c] = $urandom_range(0, 65535) >> $urandom_range(0, 10);
                spread[c] = (1 << $urandom_range(0, 12)) - 1;
            end
            for (k = 0; k < SAMPLES; k++) begin
                bt.ok = ($urandom_range(0, 24) != 0);
                for (c = 0; c < MAX_CH; c++)
                    bt.smp[c] = draw_sample(center[c], spread[c]);
                sample_beats.push_back(bt);
                queued_cnt++;
                made++;
            end
        end
    endtask

    // Register writes go in back to back; the shadow follows at the same time.
    // Only called with the block idle.
    task automatic apply_settings(input int shift, input int fence, input int minc);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= tmef_pkg::CFG_ALPHA_SHIFT;
        cfg_wdata <= CFG_DAT_W'(shift);
        shift_cfg  = ALPHA_W'(shift);
        @(negedge aclk);
        cfg_index <= tmef_pkg::CFG_FENCE_HALVES;
        cfg_wdata <= CFG_DAT_W'(fence);
        fence_cfg  = FENCE_W'(fence);
        @(negedge aclk);
        cfg_index <= tmef_pkg::CFG_MIN_CLEAN;
        cfg_wdata <= CFG_DAT_W'(minc);
        minc_cfg   = MINC_W'(minc);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Every queued beat taken and every owed result seen, then a settle window.
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            // valid holds with a steady payload until the beat goes in
            if (!s_valid || in_taken) begin
                if (sample_beats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_beat      = sample_beats.pop_front();
                    on_wire       <= next_beat;
                    s_pm1_sample  <= next_beat.smp[0];
                    s_pm25_sample <= next_beat.smp[1];
                    s_pm4_sample  <= next_beat.smp[2];
                    s_pm10_sample <= next_beat.smp[3];
                    s_read_ok     <= next_beat.ok;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both channels sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            // check the outgoing beat first: a result beat leaving now cannot
            // come from the sample beat going in on the same edge
            if (m_valid && m_ready) begin
                got.med[0] = m_pm1_median;
                got.med[1] = m_pm25_median;
                got.med[2] = m_pm4_median;
                got.med[3] = m_pm10_median;
                got.avg[0] = m_pm1_average;
                got.avg[1] = m_pm25_average;
                got.avg[2] = m_pm4_average;
                got.avg[3] = m_pm10_average;
                got.ok     = m_batch_ok;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result beat, actual batch_ok=%0b pm1_median=%0d",
                             $time, got.ok, got.med[0]);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    for (ch_i = 0; ch_i < MAX_CH; ch_i++) begin
                        if (got.med[ch_i] !== want.med[ch_i]) begin
                            $display("%0t: %s_median expected %0d, actual %0d", $time,
                                     chan_name(ch_i), want.med[ch_i], got.med[ch_i]);
                            mismatches++;
                        end
                        if (got.avg[ch_i] !== want.avg[ch_i]) begin
                            $display("%0t: %s_average expected %0d, actual %0d", $time,
                                     chan_name(ch_i), want.avg[ch_i], got.avg[ch_i]);
                            mismatches++;
                        end
                    end
                    if (got.ok !== want.ok) begin
                        $display("%0t: batch_ok expected %0b, actual %0b",
                                 $time, want.ok, got.ok);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                absorb_sample(on_wire);
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int ph;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        queued_cnt    = 0;
        accepted_cnt  = 0;
        mismatches    = 0;

        // shadow comes out of reset like the block
        shift_cfg  = tmef_pkg::ALPHA_RST;
        fence_cfg  = tmef_pkg::FENCE_RST;
        minc_cfg   = tmef_pkg::MINC_RST;
        fill_cnt   = 0;
        ema_primed = 1'b0;
        for (ph = 0; ph < MAX_CH; ph++)
            ema_val[ph] = '0;

        sender_idle_pct   = 36;
        receiver_idle_pct = 76;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed part, reset settings (shift 2, fence 1.5, min_clean 3) ---

        // failed read straight out of reset: zero averages, batch_ok low
        push_beat(17'h1FFFF, 17'h0FFFF, 17'h10000, 17'h00000, 1'b0);

        // field extremes: full scale, most negative, minus one, zero
        push_beat(17'h0FFFF, 17'h10000, 17'h1FFFF, 17'h00000, 1'b1);
        push_beat(17'h00000, 17'h0FFFF, 17'h00001, 17'h10000, 1'b1);
        push_beat(17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 1'b1);
        push_beat(17'h08000, 17'h00000, 17'h10000, 17'h0FFFF, 1'b1);
        push_beat(17'h00001, 17'h1FFFF, 17'h0FFFF, 17'h0AAAA, 1'b1);

        // two samples, then a failed read abandons the partial batch
        push_beat(17'd100, 17'd100, 17'd100, 17'd100, 1'b1);
        push_beat(17'd101, 17'd101, 17'd101, 17'd101, 1'b1);
        push_beat(17'd0, 17'd0, 17'd0, 17'd0, 1'b0);

        // outliers: high spike on pm1, flat pm25 (zero IQR), full-scale spike
        // on pm4, low dip on pm10
        push_beat(17'd100, 17'd500, 17'd0,     17'd1000, 1'b1);
        push_beat(17'd101, 17'd500, 17'd0,     17'd3,    1'b1);
        push_beat(17'd102, 17'd500, 17'd0,     17'd1001, 1'b1);
        push_beat(17'd103, 17'd500, 17'd0,     17'd1002, 1'b1);
        push_beat(17'd60000, 17'd500, 17'd65535, 17'd1003, 1'b1);

        // all negative: medians drop to zero, averages step down and truncate
        push_beat(17'h10000, 17'h1FFFF, 17'h1FF00, 17'h10001, 1'b1);
        push_beat(17'h1FFFF, 17'h10000, 17'h10001, 17'h1FF00, 1'b1);
        push_beat(17'h1FF00, 17'h10001, 17'h10000, 17'h1FFFF, 1'b1);
        push_beat(17'h10001, 17'h1FF00, 17'h1FFFF, 17'h10000, 1'b1);
        push_beat(17'h18000, 17'h18000, 17'h18000, 17'h18000, 1'b1);
        wait_drained();

        // --- random part: a new register setting per phase, extremes included ---
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            // sender idles less than receiver, then the reverse, then no idling
            case (ph / 2)
                0: begin
                    sender_idle_pct   = 36;
                    receiver_idle_pct = 76;
                end
                1: begin
                    sender_idle_pct   = 76;
                    receiver_idle_pct = 36;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            case (ph)
                0:       apply_settings(0, 0, 1);
                1:       apply_settings(7, 15, 31);   // beyond SAMPLES: plain median only
                2:       apply_settings(4, 3, 5);
                3:       apply_settings(5, 1, 0);     // zero: cleaned median always
                4:       apply_settings(1, 8, 16);
                default: apply_settings(3, 2, 2);
            endcase
            queue_random_batches(PHASE_BEATS);
            wait_drained();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
